@@ rtl/core/hid_mouse_move_reporter_assert.svh @@
// ----------------------------------------------------------------------------
// hid_mouse_move_reporter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HID_MOUSE_MOVE_REPORTER_ASSERT_SVH
`define HID_MOUSE_MOVE_REPORTER_ASSERT_SVH

// check cons in the same cycle as ante
`define HMMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define HMMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hmmr_pkg.sv @@
// ----------------------------------------------------------------------------
// hmmr_pkg
// Shared widths, types and gain table of the mouse move reporter.
// ----------------------------------------------------------------------------
`default_nettype none

package hmmr_pkg;

  localparam int GAIN_W  = 8;
  localparam int MAXD_W  = 10;
  localparam int NUM_W   = 15;
  localparam int SENS_W  = 8;
  localparam int MODE_W  = 2;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 8'd32;
  localparam logic [SENS_W-1:0] SENS_MIN   = 8'd1;
  localparam logic [SENS_W-1:0] SENS_MAX   = 8'd20;

  localparam logic [MODE_W-1:0] MODE_TABLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENHANCED = 2'd1;

  localparam logic [CFG_AW-1:0] ADDR_SENSITIVITY = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_PRECISION   = 3'd4;

  typedef enum logic [1:0] {
    KIND_MOVE,
    KIND_PRESS,
    KIND_RELEASE,
    KIND_RELEASE_ALL
  } kind_e;

  typedef struct packed {
    logic [GAIN_W-1:0] f;
    logic [MAXD_W-1:0] maxd;
  } gain_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [GAIN_W-1:0] gain_lut(input logic [4:0] s);
    logic [GAIN_W-1:0] g;
    case (s)
      5'd1:    g = 8'd1;
      5'd2:    g = 8'd2;
      5'd3:    g = 8'd4;
      5'd4:    g = 8'd8;
      5'd5:    g = 8'd12;
      5'd6:    g = 8'd16;
      5'd7:    g = 8'd20;
      5'd8:    g = 8'd24;
      5'd9:    g = 8'd28;
      5'd10:   g = 8'd32;
      5'd11:   g = 8'd40;
      5'd12:   g = 8'd48;
      5'd13:   g = 8'd56;
      5'd14:   g = 8'd64;
      5'd15:   g = 8'd72;
      5'd16:   g = 8'd80;
      5'd17:   g = 8'd88;
      5'd18:   g = 8'd96;
      5'd19:   g = 8'd104;
      5'd20:   g = 8'd112;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hmmr_cfg.sv @@
// ----------------------------------------------------------------------------
// hmmr_cfg
// APB register file for sensitivity and precision mode; derives the gain.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmr_cfg #(
  parameter int MAX_SPEED = 127
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hmmr_pkg::CFG_AW-1:0]   paddr,
  input  logic [hmmr_pkg::CFG_DW-1:0]   pwdata,
  output logic [hmmr_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output hmmr_pkg::gain_t               gain_o
);

  localparam logic REG_SENS = hmmr_pkg::ADDR_SENSITIVITY[2];
  localparam logic REG_MODE = hmmr_pkg::ADDR_PRECISION[2];
  localparam logic [6:0] MaxSpeedC = 7'(MAX_SPEED);

  logic [hmmr_pkg::SENS_W-1:0] sens_q;
  logic [hmmr_pkg::MODE_W-1:0] mode_q;
  logic                        wr_en;
  logic                        valid_set;
  logic [hmmr_pkg::GAIN_W-1:0] f;
  logic [14:0]                 prod;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= 8'd10;
      mode_q <= hmmr_pkg::MODE_ENHANCED;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SENS: sens_q <= pwdata[hmmr_pkg::SENS_W-1:0];
        REG_MODE: mode_q <= pwdata[hmmr_pkg::MODE_W-1:0];
        default:  sens_q <= sens_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SENS: prdata = 32'(sens_q);
      REG_MODE: prdata = 32'(mode_q);
      default:  prdata = '0;
    endcase
  end

  assign valid_set = (sens_q >= hmmr_pkg::SENS_MIN) && (sens_q <= hmmr_pkg::SENS_MAX) &&
                     ((mode_q == hmmr_pkg::MODE_TABLE) || (mode_q == hmmr_pkg::MODE_ENHANCED));

  always_comb begin
    if (!valid_set) begin
      f = hmmr_pkg::UNITY_GAIN;
    end else if (mode_q == hmmr_pkg::MODE_ENHANCED) begin
      f = {sens_q[4:0], 3'b000};
    end else begin
      f = hmmr_pkg::gain_lut(sens_q[4:0]);
    end
  end

  assign prod        = 15'(f) * 15'(MaxSpeedC);
  assign gain_o.f    = f;
  assign gain_o.maxd = prod[14:5];

endmodule

`default_nettype wire

@@ rtl/core/hmmr_sdiv.sv @@
// ----------------------------------------------------------------------------
// hmmr_sdiv
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmr_sdiv #(
  parameter int QW = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hmmr_pkg::NUM_W-1:0]   num_i,
  input  logic [hmmr_pkg::GAIN_W-1:0]  den_i,
  output hmmr_pkg::div_stat_t          stat_o,
  output logic [QW-1:0]                quo_o
);

  localparam int CW = $clog2(QW + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CW-1:0]               cnt_q;
  logic [hmmr_pkg::GAIN_W-1:0] rem_q;
  logic [hmmr_pkg::GAIN_W-1:0] den_q;
  logic [QW-1:0]               num_q;
  logic [QW-1:0]               quo_q;
  logic [hmmr_pkg::GAIN_W:0]   trial;
  logic                        qbit;
  logic [QW:0]                 quo_ext;
  logic [QW:0]                 num_ext;

  assign trial   = {rem_q, num_q[QW-1]};
  assign qbit    = trial >= {1'b0, den_q};
  assign quo_ext = {quo_q, qbit};
  assign num_ext = {num_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      num_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
        rem_q  <= hmmr_pkg::GAIN_W'(num_i >> QW);
        num_q  <= num_i[QW-1:0];
        den_q  <= den_i;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= qbit ? hmmr_pkg::GAIN_W'(trial - {1'b0, den_q})
                      : hmmr_pkg::GAIN_W'(trial);
        quo_q <= quo_ext[QW-1:0];
        num_q <= num_ext[QW-1:0];
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/hid_mouse_move_reporter.sv @@
// ----------------------------------------------------------------------------
// hid_mouse_move_reporter
// Relative mouse report generator with button byte and gain-scaled motion.
// ----------------------------------------------------------------------------
// Button items pass ST_OUT, then the output register. Move steps within tolerance pass
// ST_PREP, ST_OUT, then the output register. Other move steps pass ST_PREP, ST_DIVX,
// ST_DIVY and ST_OUT, set by the shared bit-serial divider (quotient width QW =
// clog2(MAX_SPEED+1), 7 at default), one quotient bit per cycle per axis. A new item is
// taken only in ST_IDLE, after the last result is loaded; an output stall holds ST_OUT.
// Reset: held buttons clear, sensitivity 10, precision mode 1, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hid_mouse_move_reporter_assert.svh"

module hid_mouse_move_reporter #(
  parameter int MAX_SPEED = 127
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hmmr_pkg::CFG_AW-1:0]  paddr,
  input  logic [hmmr_pkg::CFG_DW-1:0]  pwdata,
  output logic [hmmr_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [7:0]                   button_mask_i,
  input  logic signed [15:0]           current_x_i,
  input  logic signed [15:0]           current_y_i,
  input  logic signed [15:0]           target_x_i,
  input  logic signed [15:0]           target_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         report_valid_o,
  output logic [7:0]                   button_bits_o,
  output logic signed [7:0]            x_speed_o,
  output logic signed [7:0]            y_speed_o,
  output logic                         arrived_o
);

  localparam int QW = $clog2(MAX_SPEED + 1);
  localparam logic [QW-1:0] MaxQuoC = QW'(MAX_SPEED);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVX,
    ST_DIVY,
    ST_OUT
  } state_e;

  hmmr_pkg::gain_t     gain;
  hmmr_pkg::div_stat_t div_stat;
  logic [QW-1:0]       div_quo;
  logic                div_start;
  logic [hmmr_pkg::NUM_W-1:0] div_num;

  state_e      state_q;
  logic [7:0]  held_q;
  logic [16:0] dx_q;
  logic [16:0] dy_q;
  logic [hmmr_pkg::NUM_W-1:0] numy_q;
  logic        negx_q;
  logic        negy_q;
  logic [7:0]  xs_q;
  logic [7:0]  ys_q;
  logic        rv_q;
  logic        arr_q;
  logic        out_valid_q;
  logic        out_rv_q;
  logic [7:0]  out_btn_q;
  logic [7:0]  out_xs_q;
  logic [7:0]  out_ys_q;
  logic        out_arr_q;

  logic        in_acc;
  logic        out_free;
  logic [16:0] ax;
  logic [16:0] ay;
  logic        arr_c;
  logic [hmmr_pkg::MAXD_W-1:0] magx;
  logic [hmmr_pkg::MAXD_W-1:0] magy;
  logic [hmmr_pkg::NUM_W-1:0]  numx_c;
  logic [hmmr_pkg::NUM_W-1:0]  numy_c;
  logic [7:0]  quo_ext;

  hmmr_cfg #(
    .MAX_SPEED(MAX_SPEED)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .gain_o (gain)
  );

  hmmr_sdiv #(
    .QW(QW)
  ) u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (gain.f),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign ax = dx_q[16] ? 17'(-dx_q) : dx_q;
  assign ay = dy_q[16] ? 17'(-dy_q) : dy_q;

  assign arr_c = (ax <= 17'd3) && (ay <= 17'd3) &&
                 !((ax == 17'd3) && (ay != 17'd0)) &&
                 !((ay == 17'd3) && (ax != 17'd0));

  assign magx = (ax > 17'(gain.maxd)) ? gain.maxd : ax[hmmr_pkg::MAXD_W-1:0];
  assign magy = (ay > 17'(gain.maxd)) ? gain.maxd : ay[hmmr_pkg::MAXD_W-1:0];

  assign numx_c = {magx, 5'b00000} + hmmr_pkg::NUM_W'(gain.f) - hmmr_pkg::NUM_W'(1);
  assign numy_c = {magy, 5'b00000} + hmmr_pkg::NUM_W'(gain.f) - hmmr_pkg::NUM_W'(1);

  assign div_start = ((state_q == ST_PREP) && !arr_c) ||
                     ((state_q == ST_DIVX) && div_stat.done);
  assign div_num   = (state_q == ST_PREP) ? numx_c : numy_q;
  assign quo_ext   = 8'(div_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      numy_q      <= '0;
      negx_q      <= 1'b0;
      negy_q      <= 1'b0;
      xs_q        <= '0;
      ys_q        <= '0;
      rv_q        <= 1'b0;
      arr_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_rv_q    <= 1'b0;
      out_btn_q   <= '0;
      out_xs_q    <= '0;
      out_ys_q    <= '0;
      out_arr_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !((state_q == ST_OUT) && out_free)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            xs_q  <= '0;
            ys_q  <= '0;
            rv_q  <= 1'b1;
            arr_q <= 1'b0;
            case (hmmr_pkg::kind_e'(kind_i))
              hmmr_pkg::KIND_MOVE: begin
                dx_q    <= {target_x_i[15], target_x_i} - {current_x_i[15], current_x_i};
                dy_q    <= {target_y_i[15], target_y_i} - {current_y_i[15], current_y_i};
                state_q <= ST_PREP;
              end
              hmmr_pkg::KIND_PRESS: begin
                held_q  <= held_q | button_mask_i;
                state_q <= ST_OUT;
              end
              hmmr_pkg::KIND_RELEASE: begin
                held_q  <= held_q & ~button_mask_i;
                state_q <= ST_OUT;
              end
              hmmr_pkg::KIND_RELEASE_ALL: begin
                held_q  <= '0;
                state_q <= ST_OUT;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_PREP: begin
          negx_q <= dx_q[16];
          negy_q <= dy_q[16];
          numy_q <= numy_c;
          if (arr_c) begin
            rv_q    <= 1'b0;
            arr_q   <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_DIVX;
          end
        end
        ST_DIVX: begin
          if (div_stat.done) begin
            xs_q    <= negx_q ? 8'(-quo_ext) : quo_ext;
            state_q <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_stat.done) begin
            ys_q    <= negy_q ? 8'(-quo_ext) : quo_ext;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_rv_q    <= rv_q;
            out_btn_q   <= held_q;
            out_xs_q    <= xs_q;
            out_ys_q    <= ys_q;
            out_arr_q   <= arr_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign report_valid_o = out_rv_q;
  assign button_bits_o  = out_btn_q;
  assign x_speed_o      = out_xs_q;
  assign y_speed_o      = out_ys_q;
  assign arrived_o      = out_arr_q;

  `HMMR_ASSERT_NOW(a_arrived_still, out_valid_o && arrived_o,
    !report_valid_o && (x_speed_o == 8'sd0) && (y_speed_o == 8'sd0),
    "arrived result carries a report or motion")

  `HMMR_ASSERT_NOW(a_quo_bound, div_stat.done, div_quo <= MaxQuoC,
    "divider quotient exceeds the speed limit")

  `HMMR_ASSERT_NEXT(a_y_start, (state_q == ST_DIVX) && div_stat.done,
    div_stat.busy && (state_q == ST_DIVY), "y division did not start")

  `HMMR_ASSERT_NEXT(a_out_load, (state_q == ST_OUT) && out_free,
    out_valid_o && (state_q == ST_IDLE), "result not moved to the output register")

endmodule

`default_nettype wire

@@ verif/hid_mouse_move_reporter_tb.sv @@
// ----------------------------------------------------------------------------
// hid_mouse_move_reporter_tb
// Self-checking bench: drives button and move-step transactions with random
// gaps and output stalls, programs gain settings over APB between phases,
// and compares every report against a local prediction of held buttons,
// arrival and gain-scaled axis speeds.
// ----------------------------------------------------------------------------
module hid_mouse_move_reporter_tb;

  localparam int MAX_SPEED      = 127;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 10;
  localparam int PHASE_STEPS    = 123;

  localparam logic [hmmr_pkg::MODE_W-1:0] MODE_RSVD2 = 2'd2;
  localparam logic [hmmr_pkg::MODE_W-1:0] MODE_RSVD3 = 2'd3;

  localparam logic [hmmr_pkg::GAIN_W-1:0] GAIN_BY_LEVEL [0:20] = '{
    8'd0, 8'd1, 8'd2, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28, 8'd32,
    8'd40, 8'd48, 8'd56, 8'd64, 8'd72, 8'd80, 8'd88, 8'd96, 8'd104, 8'd112
  };

  localparam logic [hmmr_pkg::SENS_W-1:0] EXT_SENS [0:5] = '{
    8'd1, 8'd20, 8'd0, 8'd20, 8'd255, 8'd1
  };
  localparam logic [hmmr_pkg::MODE_W-1:0] EXT_MODE [0:5] = '{
    hmmr_pkg::MODE_TABLE, hmmr_pkg::MODE_TABLE, hmmr_pkg::MODE_ENHANCED,
    hmmr_pkg::MODE_ENHANCED, MODE_RSVD3, MODE_RSVD2
  };

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          mask;
    logic signed [15:0]  cx;
    logic signed [15:0]  cy;
    logic signed [15:0]  tx;
    logic signed [15:0]  ty;
  } step_t;

  typedef struct packed {
    logic                report;
    logic [7:0]          buttons;
    logic signed [7:0]   xs;
    logic signed [7:0]   ys;
    logic                arrived;
  } report_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [hmmr_pkg::CFG_AW-1:0]   paddr;
  logic [hmmr_pkg::CFG_DW-1:0]   pwdata;
  logic [hmmr_pkg::CFG_DW-1:0]   prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [1:0]                    kind_i;
  logic [7:0]                    button_mask_i;
  logic signed [15:0]            current_x_i;
  logic signed [15:0]            current_y_i;
  logic signed [15:0]            target_x_i;
  logic signed [15:0]            target_y_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          report_valid_o;
  logic [7:0]                    button_bits_o;
  logic signed [7:0]             x_speed_o;
  logic signed [7:0]             y_speed_o;
  logic                          arrived_o;

  report_t                       pending_reports[$];
  logic [7:0]                    held_mask;
  logic [hmmr_pkg::SENS_W-1:0]   cur_sens;
  logic [hmmr_pkg::MODE_W-1:0]   cur_mode;
  int                            mismatches;
  int                            quiet_cycles;
  int                            stall_left;
  bit                            idle_on;

  hid_mouse_move_reporter #(.MAX_SPEED(MAX_SPEED)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .button_mask_i  (button_mask_i),
    .current_x_i    (current_x_i),
    .current_y_i    (current_y_i),
    .target_x_i     (target_x_i),
    .target_y_i     (target_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .report_valid_o (report_valid_o),
    .button_bits_o  (button_bits_o),
    .x_speed_o      (x_speed_o),
    .y_speed_o      (y_speed_o),
    .arrived_o      (arrived_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int active_gain();
    if (cur_sens < hmmr_pkg::SENS_MIN || cur_sens > hmmr_pkg::SENS_MAX ||
        cur_mode > hmmr_pkg::MODE_ENHANCED) begin
      return int'(hmmr_pkg::UNITY_GAIN);
    end
    if (cur_mode == hmmr_pkg::MODE_ENHANCED) begin
      return 8 * int'(cur_sens);
    end
    return int'(GAIN_BY_LEVEL[cur_sens]);
  endfunction

  function automatic logic signed [7:0] axis_speed(input int d, input int f);
    int maxd;
    int mag;
    int sp;
    maxd = (f * MAX_SPEED) / 32;
    mag  = (d < 0) ? -d : d;
    if (mag > maxd) begin
      mag = maxd;
    end
    sp = (32 * mag + f - 1) / f;
    return (d < 0) ? 8'(-sp) : 8'(sp);
  endfunction

  function automatic report_t predict_report(input step_t s);
    report_t r;
    int      dx;
    int      dy;
    longint  sq;
    r = '{report: 1'b1, buttons: 8'd0, xs: 8'sd0, ys: 8'sd0, arrived: 1'b0};
    case (s.kind)
      hmmr_pkg::KIND_MOVE: begin
        dx = int'(s.tx) - int'(s.cx);
        dy = int'(s.ty) - int'(s.cy);
        sq = longint'(dx) * dx + longint'(dy) * dy;
        if (sq <= 9) begin
          r.report  = 1'b0;
          r.arrived = 1'b1;
        end else begin
          r.xs = axis_speed(dx, active_gain());
          r.ys = axis_speed(dy, active_gain());
        end
      end
      hmmr_pkg::KIND_PRESS:   held_mask = held_mask | s.mask;
      hmmr_pkg::KIND_RELEASE: held_mask = held_mask & ~s.mask;
      default:                held_mask = 8'd0;
    endcase
    r.buttons = held_mask;
    return r;
  endfunction

  function automatic step_t make_step(input logic [1:0] kind, input logic [7:0] mask,
                                      input int cx, input int cy, input int tx, input int ty);
    step_t s;
    s.kind = kind;
    s.mask = mask;
    s.cx   = 16'(cx);
    s.cy   = 16'(cy);
    s.tx   = 16'(tx);
    s.ty   = 16'(ty);
    return s;
  endfunction

  function automatic step_t random_step();
    step_t s;
    int    pick;
    s.mask = 8'($urandom);
    s.cx   = 16'($urandom);
    s.cy   = 16'($urandom);
    s.tx   = 16'($urandom);
    s.ty   = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      s.kind = hmmr_pkg::KIND_PRESS;
    end else if (pick < 38) begin
      s.kind = hmmr_pkg::KIND_RELEASE;
    end else if (pick < 45) begin
      s.kind = hmmr_pkg::KIND_RELEASE_ALL;
    end else begin
      s.kind = hmmr_pkg::KIND_MOVE;
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        s.tx = 16'(int'(s.cx) + int'($urandom_range(0, 8)) - 4);
        s.ty = 16'(int'(s.cy) + int'($urandom_range(0, 8)) - 4);
      end else if (pick == 1) begin
        s.tx = 16'(int'(s.cx) + int'($urandom_range(0, 1200)) - 600);
        s.ty = 16'(int'(s.cy) + int'($urandom_range(0, 1200)) - 600);
      end
    end
    return s;
  endfunction

  task automatic send_step(input step_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 17)) @(negedge clk_i) in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    kind_i        <= s.kind;
    button_mask_i <= s.mask;
    current_x_i   <= s.cx;
    current_y_i   <= s.cy;
    target_x_i    <= s.tx;
    target_y_i    <= s.ty;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pending_reports.push_back(predict_report(s));
  endtask

  task automatic wait_drained();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_read(input logic [hmmr_pkg::CFG_AW-1:0] addr,
                          output logic [hmmr_pkg::CFG_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic [hmmr_pkg::CFG_AW-1:0] addr);
    logic [hmmr_pkg::CFG_DW-1:0] rd;
    logic [hmmr_pkg::CFG_DW-1:0] want;
    logic [hmmr_pkg::CFG_DW-1:0] got;
    cfg_read(addr, rd);
    if (addr == hmmr_pkg::ADDR_SENSITIVITY) begin
      want = hmmr_pkg::CFG_DW'(cur_sens);
      got  = hmmr_pkg::CFG_DW'(rd[hmmr_pkg::SENS_W-1:0]);
    end else begin
      want = hmmr_pkg::CFG_DW'(cur_mode);
      got  = hmmr_pkg::CFG_DW'(rd[hmmr_pkg::MODE_W-1:0]);
    end
    if (got !== want) begin
      $display("%0t: register 0x%0h expected %0d got %0d", $time, addr, want, got);
      mismatches++;
    end
  endtask

  task automatic cfg_write(input logic [hmmr_pkg::CFG_AW-1:0] addr,
                           input logic [hmmr_pkg::CFG_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (addr == hmmr_pkg::ADDR_SENSITIVITY) begin
      cur_sens = data[hmmr_pkg::SENS_W-1:0];
    end else begin
      cur_mode = data[hmmr_pkg::MODE_W-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_register(addr);
  endtask

  task automatic set_gain(input logic [hmmr_pkg::SENS_W-1:0] sens,
                          input logic [hmmr_pkg::MODE_W-1:0] mode);
    wait_drained();
    cfg_write(hmmr_pkg::ADDR_SENSITIVITY, hmmr_pkg::CFG_DW'(sens));
    cfg_write(hmmr_pkg::ADDR_PRECISION, hmmr_pkg::CFG_DW'(mode));
  endtask

  task automatic check_field(input string what, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic test_register_reset();
    check_register(hmmr_pkg::ADDR_SENSITIVITY);
    check_register(hmmr_pkg::ADDR_PRECISION);
  endtask

  task automatic test_button_ops();
    send_step(make_step(hmmr_pkg::KIND_PRESS, 8'hFF, 0, 0, 0, 0));
    send_step(make_step(hmmr_pkg::KIND_RELEASE, 8'h0F, -1, 5, 7, -9));
    send_step(make_step(hmmr_pkg::KIND_PRESS, 8'h00, 0, 0, 0, 0));
    send_step(make_step(hmmr_pkg::KIND_RELEASE, 8'hFF, 0, 0, 0, 0));
    send_step(make_step(hmmr_pkg::KIND_PRESS, 8'hA5, 0, 0, 0, 0));
    send_step(make_step(hmmr_pkg::KIND_RELEASE_ALL, 8'h5A, 0, 0, 0, 0));
    send_step(make_step(hmmr_pkg::KIND_PRESS, 8'h80, 0, 0, 0, 0));
  endtask

  task automatic test_move_steps();
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'hFF, 100, -100, 100, -100));
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, 3, 0));
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 10, 10, 12, 12));
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, 0, -3));
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, 3, 1));
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, 2, -3));
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, -32768, -32768, 32767, 32767));
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 32767, 32767, -32768, -32768));
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, 1, -4));
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 500, -200, 180, 117));
  endtask

  task automatic test_gain_extremes();
    set_gain(8'd1, hmmr_pkg::MODE_TABLE);
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, 2, -5));
    set_gain(8'd20, hmmr_pkg::MODE_ENHANCED);
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, 32767, -32768));
    set_gain(8'd21, hmmr_pkg::MODE_TABLE);
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, -40, 200));
    set_gain(8'd10, MODE_RSVD2);
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, 7, -127));
    set_gain(8'd0, hmmr_pkg::MODE_TABLE);
    send_step(make_step(hmmr_pkg::KIND_MOVE, 8'h00, 0, 0, 128, -4));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 6) begin
        set_gain(EXT_SENS[phase], EXT_MODE[phase]);
      end else if ($urandom_range(0, 1) == 0) begin
        set_gain(8'($urandom_range(0, 21)), 2'($urandom_range(0, 3)));
      end else begin
        set_gain(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
      end
      idle_on = (phase != PHASES - 1);
      repeat (PHASE_STEPS) send_step(random_step());
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left  <= $urandom_range(1, 17) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: report transaction expected none got buttons %0h x %0d y %0d",
                   $time, button_bits_o, x_speed_o, y_speed_o);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("report_valid", 16'(want.report), 16'(report_valid_o));
          check_field("button_bits", 16'(want.buttons), 16'(button_bits_o));
          check_field("x_speed", want.xs, x_speed_o);
          check_field("y_speed", want.ys, y_speed_o);
          check_field("arrived", 16'(want.arrived), 16'(arrived_o));
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    kind_i        = hmmr_pkg::KIND_MOVE;
    button_mask_i = 8'd0;
    current_x_i   = 16'sd0;
    current_y_i   = 16'sd0;
    target_x_i    = 16'sd0;
    target_y_i    = 16'sd0;
    out_ready_i   = 1'b0;
    held_mask     = 8'd0;
    cur_sens      = 8'd10;
    cur_mode      = hmmr_pkg::MODE_ENHANCED;
    mismatches    = 0;
    quiet_cycles  = 0;
    stall_left    = 0;
    idle_on       = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_register_reset();
    test_button_ops();
    test_move_steps();
    test_gain_extremes();
    test_random_traffic();

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
